// ----- rtl/semaphore_table_with_wait_queues_unit_macros.svh -----
// Assertion macros for the semaphore table unit.
// Used by the top level; needs a clock named clock and a reset named reset in scope.
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_UNIT_MACROS_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check an overlapping implication property, masked while reset is high.
`define STWQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that cons holds in the cycle after ante.
`define STWQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STWQ_ASSERT(label, prop, msg)
`define STWQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/stwq_pkg.sv -----
// Shared types and codes for the semaphore table unit.
// No dependencies; imported by the controller, the datapath and the top level.
package stwq_pkg;

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_WAIT   = 2'd1;
   localparam logic [1:0] REQ_POST   = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_ENTRY   = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd2;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_FREE,
      S_SCAN,
      S_STATE,
      S_WAKE,
      S_RESULT
   } stwq_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic claim;
      logic no_entry;
      logic apply;
      logic wake;
      logic rsp_load;
   } stwq_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       used_at_scan;
      logic       scan_last;
      logic       hit;
      logic       miss;
      logic       pops;
      logic       rsp_free;
   } stwq_stat_type;

endpackage

// ----- rtl/stwq_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module stwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stwq_ctrl.sv -----
// Sequencer for the semaphore table: steps each request through scan, update, result.
// Depends on stwq_pkg; drives the datapath by command struct only.
module stwq_ctrl
   import stwq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  stwq_stat_type stat,
   output stwq_cmd_type  cmd
);

   stwq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.req_type)
               REQ_CREATE:         state_in = S_FREE;
               REQ_WAIT, REQ_POST: state_in = S_SCAN;
               default:            state_in = S_RESULT;
            endcase
         end
         S_FREE: begin
            if (!stat.used_at_scan) begin
               cmd.claim = 1'b1;
               state_in  = S_RESULT;
            end else if (stat.scan_last) begin
               cmd.no_entry = 1'b1;
               state_in     = S_RESULT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               state_in = S_STATE;
            end else if (stat.miss) begin
               state_in = S_RESULT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_STATE: begin
            cmd.apply = 1'b1;
            state_in  = stat.pops ? S_WAKE : S_RESULT;
         end
         S_WAKE: begin
            cmd.wake = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/stwq_dp.sv -----
// Datapath of the semaphore table: used bits, key/state/waiter memories, result registers.
// Depends on stwq_pkg and stwq_ram; acts only on controller commands.
module stwq_dp
   import stwq_pkg::*;
#(
   parameter int NUM_SEMAPHORES = 8,
   parameter int QUEUE_DEPTH    = 8,
   parameter int CALLER_ID_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  stwq_cmd_type  cmd,
   output stwq_stat_type stat,
   input  logic [1:0]    req_type,
   input  logic [63:0]   sem_key,
   input  logic [15:0]   start_count,
   input  logic [7:0]    caller_id,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [1:0]    rsp_status,
   output logic          rsp_must_block,
   output logic          rsp_wake_valid,
   output logic [7:0]    rsp_wake_id
);

   localparam int IDX_W  = $clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int WQ_N   = NUM_SEMAPHORES * QUEUE_DEPTH;
   localparam int WA_W   = $clog2(WQ_N > 1 ? WQ_N : 2);
   localparam int ST_W   = 16 + 2 * PTR_W + FILL_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SEMAPHORES - 1);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] pos);
      logic [PTR_W-1:0] res;
      res = (pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pos + PTR_W'(1);
      return res;
   endfunction

   // Request registers
   logic [1:0]  req_type_ff;
   logic [63:0] req_key_ff;
   logic [15:0] req_start_ff;
   logic [7:0]  req_caller_ff;

   logic [NUM_SEMAPHORES-1:0] used_ff;
   logic [IDX_W-1:0] scan_idx_ff, cmp_idx_ff;
   logic             cmp_valid_ff;

   logic [1:0] res_status_ff;
   logic       res_block_ff, res_wvalid_ff;
   logic [7:0] res_wid_ff;

   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_block_ff, rsp_wvalid_ff;
   logic [7:0] rsp_wid_ff;

   // Memory ports
   logic [63:0]               key_rd;
   logic [ST_W-1:0]           st_rd, st_wr;
   logic                      st_we;
   logic [IDX_W-1:0]          st_waddr;
   logic [CALLER_ID_BITS-1:0] wq_rd, wq_wr;
   logic                      wq_we;
   logic [WA_W-1:0]           wq_base, wq_waddr, wq_raddr;

   logic [15:0]       cur_count, new_count;
   logic [PTR_W-1:0]  cur_head, cur_tail, new_head, new_tail;
   logic [FILL_W-1:0] cur_fill, new_fill;
   logic              count_zero, q_full, q_empty, key_match;
   logic [15:0]       caller16, wake16;
   logic [1:0]        apply_status;
   logic              apply_block;

   stwq_ram #(.WIDTH(64), .DEPTH(NUM_SEMAPHORES)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.claim),
      .wr_addr (scan_idx_ff),
      .wr_data (req_key_ff),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd)
   );

   stwq_ram #(.WIDTH(ST_W), .DEPTH(NUM_SEMAPHORES)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wr),
      .rd_addr (cmp_idx_ff),
      .rd_data (st_rd)
   );

   stwq_ram #(.WIDTH(CALLER_ID_BITS), .DEPTH(WQ_N)) u_waiter_ram (
      .clock   (clock),
      .wr_en   (wq_we),
      .wr_addr (wq_waddr),
      .wr_data (wq_wr),
      .rd_addr (wq_raddr),
      .rd_data (wq_rd)
   );

   assign {cur_count, cur_head, cur_tail, cur_fill} = st_rd;
   assign count_zero = (cur_count == 16'd0);
   assign q_full     = (cur_fill >= FILL_W'(QUEUE_DEPTH));
   assign q_empty    = (cur_fill == '0);
   assign key_match  = (key_rd == req_key_ff);

   assign wq_base  = WA_W'(cmp_idx_ff) * WA_W'(QUEUE_DEPTH);
   assign wq_waddr = wq_base + WA_W'(cur_tail);
   assign wq_raddr = wq_base + WA_W'(cur_head);
   assign caller16 = 16'(req_caller_ff);
   assign wq_wr    = caller16[CALLER_ID_BITS-1:0];
   assign wake16   = 16'(wq_rd);

   // Decide the queue/count update for the matched entry
   always_comb begin
      new_count    = cur_count;
      new_head     = cur_head;
      new_tail     = cur_tail;
      new_fill     = cur_fill;
      apply_status = ST_OK;
      apply_block  = 1'b0;
      wq_we        = 1'b0;
      case (req_type_ff)
         REQ_WAIT: begin
            if (!count_zero) begin
               new_count = cur_count - 16'd1;
            end else if (q_full) begin
               apply_status = ST_QUEUE_FULL;
            end else begin
               wq_we       = cmd.apply;
               new_tail    = next_slot(cur_tail);
               new_fill    = cur_fill + FILL_W'(1);
               apply_block = 1'b1;
            end
         end
         REQ_POST: begin
            if (!q_empty) begin
               new_head = next_slot(cur_head);
               new_fill = cur_fill - FILL_W'(1);
            end else if (cur_count != COUNT_MAX) begin
               new_count = cur_count + 16'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      st_we    = cmd.claim | cmd.apply;
      st_waddr = cmd.claim ? scan_idx_ff : cmp_idx_ff;
      st_wr    = cmd.claim ? {req_start_ff, {PTR_W{1'b0}}, {PTR_W{1'b0}}, {FILL_W{1'b0}}}
                           : {new_count, new_head, new_tail, new_fill};
   end

   always_comb begin
      stat.req_type     = req_type_ff;
      stat.used_at_scan = used_ff[scan_idx_ff];
      stat.scan_last    = (scan_idx_ff == IDX_LAST);
      stat.hit          = cmp_valid_ff && used_ff[cmp_idx_ff] && key_match;
      stat.miss         = cmp_valid_ff && (cmp_idx_ff == IDX_LAST) && !stat.hit;
      stat.pops         = (req_type_ff == REQ_POST) && !q_empty;
      stat.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff   <= req_type;
         req_key_ff    <= sem_key;
         req_start_ff  <= start_count;
         req_caller_ff <= caller_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         scan_idx_ff  <= '0;
         cmp_idx_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            scan_idx_ff  <= '0;
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_idx_ff   <= scan_idx_ff;
            cmp_valid_ff <= 1'b1;
            if (scan_idx_ff != IDX_LAST) begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
         end
         if (cmd.claim) begin
            used_ff[scan_idx_ff] <= 1'b1;
         end
      end
   end

   // Result being built for the current request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_status_ff <= ST_OK;
         res_block_ff  <= 1'b0;
         res_wvalid_ff <= 1'b0;
         res_wid_ff    <= 8'd0;
      end else begin
         if (cmd.no_entry) begin
            res_status_ff <= ST_NO_ENTRY;
         end
         if (cmd.apply) begin
            res_status_ff <= apply_status;
            res_block_ff  <= apply_block;
         end
         if (cmd.wake) begin
            res_wvalid_ff <= 1'b1;
            res_wid_ff    <= wake16[7:0];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_wvalid_ff <= res_wvalid_ff;
         rsp_wid_ff    <= res_wid_ff;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_must_block = rsp_block_ff;
   assign rsp_wake_valid = rsp_wvalid_ff;
   assign rsp_wake_id    = rsp_wid_ff;

endmodule

// ----- rtl/semaphore_table_with_wait_queues_unit.sv -----
// Top level of the semaphore table unit: stream ports, controller and datapath.
// Depends on stwq_pkg, stwq_ctrl, stwq_dp, stwq_ram and the unit's macro header.
//
// A table of NUM_SEMAPHORES counting semaphores, each named by a 64-bit key,
// with a FIFO of up to QUEUE_DEPTH blocked callers per semaphore. Requests
// arrive on the req_ stream (req_tuser: 0 create, 1 wait, 2 post) and each
// produces exactly one transfer on the rsp_ stream. Create takes the lowest
// unused entry; wait and post act on the lowest used entry whose key matches
// and do nothing for an unknown key. Entries are never freed. The unit works
// on one request at a time: after accepting it, it decodes the request, then
// scans the table one entry per cycle, for a wait or post through the single
// read port of the key memory (priming the read, then comparing one entry at
// a time), then updates the count and queue (or claims the free entry on a
// create), reads the woken caller on a post that pops, and loads the output
// register.
// The next request is taken while a finished result still waits in the
// output register. Table occupancy is held in flip-flops cleared by reset,
// so no clearing pass runs after reset.
`include "semaphore_table_with_wait_queues_unit_macros.svh"

module semaphore_table_with_wait_queues_unit
   import stwq_pkg::*;
#(
   parameter int NUM_SEMAPHORES = 8,
   parameter int QUEUE_DEPTH    = 8,
   parameter int CALLER_ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // sem_key[63:0], start_count[79:64], caller_id[87:80]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // must_block[0], wake_valid[1], wake_id[9:2], zero[15:10]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   stwq_cmd_type  cmd;
   stwq_stat_type stat;

   logic [1:0] rsp_status;
   logic       rsp_must_block;
   logic       rsp_wake_valid;
   logic [7:0] rsp_wake_id;

   // Sequence each request
   stwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the table, the queues and the result
   stwq_dp #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .CALLER_ID_BITS (CALLER_ID_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_tuser),
      .sem_key        (req_tdata[63:0]),
      .start_count    (req_tdata[79:64]),
      .caller_id      (req_tdata[87:80]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_must_block (rsp_must_block),
      .rsp_wake_valid (rsp_wake_valid),
      .rsp_wake_id    (rsp_wake_id)
   );

   // Pack the result transfer
   assign rsp_tdata = {6'd0, rsp_wake_id, rsp_wake_valid, rsp_must_block};
   assign rsp_tuser = rsp_status;

   // One request in flight: no accept right after an accept
   `STWQ_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   // A wake only follows an update that popped the queue
   `STWQ_ASSERT(a_wake_after_pop, cmd.wake |-> $past(cmd.apply && stat.pops), "wake without pop")
   // An error result carries no block or wake flag
   `STWQ_ASSERT(a_err_no_flags, rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[1:0] == 2'b00, "flags on error")
   // wake_id is zero unless a waiter was released
   `STWQ_ASSERT(a_wake_id_zero, rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == 8'd0, "stray wake id")

endmodule

// ----- sim/semaphore_checker.sv -----
// Scoreboard for the semaphore table unit: watches both streams, predicts each result.
// Depends on stwq_pkg for request and status codes; instantiated by the testbench top.
`timescale 1ns / 1ps

module semaphore_checker
   import stwq_pkg::*;
#(
   parameter int NUM_SEMAPHORES = 8,
   parameter int QUEUE_DEPTH    = 8,
   parameter int CALLER_ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,   // sem_key[63:0], start_count[79:64], caller_id[87:80]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // must_block[0], wake_valid[1], wake_id[9:2], zero[15:10]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   output int          fail_count,
   output int          pending_results
);

   typedef struct packed {
      logic [1:0] status;
      logic       must_block;
      logic       wake_valid;
      logic [7:0] wake_id;
   } sem_result_type;

   logic                      sem_used  [NUM_SEMAPHORES];
   logic [63:0]               sem_key   [NUM_SEMAPHORES];
   logic [15:0]               sem_count [NUM_SEMAPHORES];
   logic [CALLER_ID_BITS-1:0] waiters   [NUM_SEMAPHORES][QUEUE_DEPTH];
   int                        q_head    [NUM_SEMAPHORES];
   int                        q_tail    [NUM_SEMAPHORES];
   int                        q_fill    [NUM_SEMAPHORES];

   sem_result_type expected_results[$];

   // Apply one request to the shadow table and return the result it causes.
   function automatic sem_result_type apply_semaphore_op(input logic [1:0]  op,
                                                         input logic [63:0] key,
                                                         input logic [15:0] start,
                                                         input logic [7:0]  caller);
      sem_result_type r;
      int             slot;
      r    = '0;
      slot = -1;
      case (op)
         REQ_CREATE: begin
            for (int i = 0; i < NUM_SEMAPHORES; i++)
               if (slot < 0 && !sem_used[i]) slot = i;
            if (slot < 0) begin
               r.status = ST_NO_ENTRY;
            end else begin
               sem_used[slot]  = 1'b1;
               sem_key[slot]   = key;
               sem_count[slot] = start;
               q_head[slot]    = 0;
               q_tail[slot]    = 0;
               q_fill[slot]    = 0;
            end
         end
         REQ_WAIT, REQ_POST: begin
            // lowest matching used entry wins, duplicates behind it stay unreachable
            for (int i = 0; i < NUM_SEMAPHORES; i++)
               if (slot < 0 && sem_used[i] && sem_key[i] == key) slot = i;
            if (slot >= 0) begin
               if (op == REQ_WAIT) begin
                  if (sem_count[slot] != 16'd0) begin
                     sem_count[slot] = sem_count[slot] - 16'd1;
                  end else if (q_fill[slot] >= QUEUE_DEPTH) begin
                     r.status = ST_QUEUE_FULL;
                  end else begin
                     waiters[slot][q_tail[slot]] = CALLER_ID_BITS'(caller);
                     q_tail[slot] = (q_tail[slot] + 1) % QUEUE_DEPTH;
                     q_fill[slot]++;
                     r.must_block = 1'b1;
                  end
               end else if (q_fill[slot] > 0) begin
                  // the released unit goes straight to the oldest waiter
                  r.wake_valid = 1'b1;
                  r.wake_id    = 8'(waiters[slot][q_head[slot]]);
                  q_head[slot] = (q_head[slot] + 1) % QUEUE_DEPTH;
                  q_fill[slot]--;
               end else if (sem_count[slot] != COUNT_MAX) begin
                  sem_count[slot] = sem_count[slot] + 16'd1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      sem_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            sem_used[i] = 1'b0;
            q_head[i]   = 0;
            q_tail[i]   = 0;
            q_fill[i]   = 0;
         end
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_tuser));
               check_field("must_block", 16'(want.must_block), 16'(rsp_tdata[0]));
               check_field("wake_valid", 16'(want.wake_valid), 16'(rsp_tdata[1]));
               check_field("wake_id", 16'(want.wake_id), 16'(rsp_tdata[9:2]));
               check_field("padding", 16'd0, 16'(rsp_tdata[15:10]));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_semaphore_op(req_tuser, req_tdata[63:0],
                                                          req_tdata[79:64], req_tdata[87:80]));
      end
      pending_results = expected_results.size();
   end

endmodule

// ----- sim/tb_semaphore_table_with_wait_queues_unit.sv -----
// Testbench top for the semaphore table unit: clock, reset, stimulus and verdict.
// Depends on stwq_pkg, the unit itself and semaphore_checker, which does all prediction.
`timescale 1ns / 1ps

module tb_semaphore_table_with_wait_queues_unit;
   import stwq_pkg::*;

   localparam int NUM_SEMAPHORES = 8;
   localparam int QUEUE_DEPTH    = 8;
   localparam int CALLER_ID_BITS = 8;

   // The package leaves the fourth request code unnamed; the unit must ignore it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1075;
   localparam int IDLE_PERCENT = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;   // sem_key[63:0], start_count[79:64], caller_id[87:80]
   logic [1:0]  req_tuser;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // must_block[0], wake_valid[1], wake_id[9:2], zero[15:10]
   logic [1:0]  rsp_tuser;   // status[1:0]

   int fail_count;
   int pending_results;

   // Both sides idle at random unless this is set; the hold request parks the
   // receiver for a long stretch so the unit backs up into its request port.
   bit no_idle      = 1'b0;
   bit hold_request = 1'b0;

   // Keys of the table entries in creation order, so that most random
   // traffic hits live semaphores and reaches the wait queues.
   logic [63:0] live_keys[NUM_SEMAPHORES];

   semaphore_table_with_wait_queues_unit #(
      .NUM_SEMAPHORES(NUM_SEMAPHORES),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .CALLER_ID_BITS(CALLER_ID_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   semaphore_checker #(
      .NUM_SEMAPHORES(NUM_SEMAPHORES),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .CALLER_ID_BITS(CALLER_ID_BITS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .pending_results(pending_results)
   );

   // 4 ns period, high then low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Drive one request and hold it until the transfer completes. Inputs
   // change only at the falling edge; ready is sampled at the rising edge.
   // Valid stays high on return so back-to-back requests need no gap.
   task automatic offer_request(input logic [1:0]  op,
                                input logic [63:0] key,
                                input logic [15:0] start,
                                input logic [7:0]  caller);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {caller, start, key};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_key();
      return {$urandom(), $urandom()};
   endfunction

   // Receiver: stall at random, or for a long counted stretch on request.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int          focus;
      int          pick;
      logic [1:0]  op;
      logic [63:0] key;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_CREATE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. An empty table: unknown keys and the unused code do nothing.
      offer_request(REQ_WAIT, 64'h0123_4567_89ab_cdef, 16'd7, 8'h11);
      offer_request(REQ_POST, 64'hfedc_ba98_7654_3210, 16'd0, 8'h22);
      offer_request(REQ_UNUSED, '1, '1, '1);

      // Extreme keys and counts, then a duplicate key that hides behind entry 0.
      live_keys[0] = 64'd0;
      live_keys[1] = '1;
      live_keys[2] = 64'd0;
      offer_request(REQ_CREATE, live_keys[0], 16'd0, 8'h00);
      offer_request(REQ_CREATE, live_keys[1], 16'hffff, 8'hff);
      offer_request(REQ_CREATE, live_keys[2], 16'd5, 8'h5a);

      // Fill entry 0's queue, then overflow it.
      offer_request(REQ_WAIT, live_keys[0], 16'hffff, 8'hff);
      offer_request(REQ_WAIT, live_keys[0], 16'd0, 8'h00);
      for (int i = 0; i < QUEUE_DEPTH - 2; i++)
         offer_request(REQ_WAIT, live_keys[0], 16'd0, 8'(8'h30 + i));
      offer_request(REQ_WAIT, live_keys[0], 16'd0, 8'h99);

      // Wake the oldest waiter, saturate a full count, then take one unit.
      offer_request(REQ_POST, live_keys[0], 16'd0, 8'h00);
      offer_request(REQ_POST, live_keys[1], 16'd0, 8'h00);
      offer_request(REQ_WAIT, live_keys[1], 16'd0, 8'h44);

      // Fill the rest of the table with small counts, then one create too many.
      for (int i = 3; i < NUM_SEMAPHORES; i++) begin
         live_keys[i] = random_key();
         offer_request(REQ_CREATE, live_keys[i], 16'($urandom_range(0, 2)), 8'h00);
      end
      offer_request(REQ_CREATE, random_key(), 16'($urandom_range(0, 65535)), 8'h00);

      // Random part: mostly waits and posts on one focus semaphore at a time,
      // so queues fill, wrap and overflow; the rest is spread or noise.
      focus = 3;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 200) no_idle = 1'b1;
         if (n == 400) no_idle = 1'b0;
         if (n == 600) hold_request = 1'b1;
         if ($urandom_range(0, 19) == 0) focus = $urandom_range(0, NUM_SEMAPHORES - 1);

         pick = $urandom_range(0, 99);
         if (pick < 46)      op = REQ_WAIT;
         else if (pick < 92) op = REQ_POST;
         else if (pick < 97) op = REQ_CREATE;
         else                op = REQ_UNUSED;

         pick = $urandom_range(0, 99);
         if (pick < 70)      key = live_keys[focus];
         else if (pick < 90) key = live_keys[$urandom_range(0, NUM_SEMAPHORES - 1)];
         else                key = random_key();

         offer_request(op, key, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
      req_tvalid = 1'b0;

      // Let every expected result come back, then watch for strays.
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
